// ===== src/assert_macros.svh =====
// assertion helpers, clocked on clk and held off during rst
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every edge
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequent checked after the antecedent, with non-overlapping implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/mpp_pkg.sv =====
`timescale 1ns / 1ps
package mpp_pkg;

  localparam int MAX_LAGS   = 1024;
  localparam int PEAK_DEPTH = 512;

  localparam int LAG_W     = $clog2(MAX_LAGS + 1);
  localparam int PTR_W     = $clog2(PEAK_DEPTH);
  localparam int CFG_LAG_W = 11;
  localparam int CMP_W     = (LAG_W > CFG_LAG_W) ? LAG_W : CFG_LAG_W;
  localparam int VAL_W     = 16;
  localparam int CORR_W    = 32;
  localparam int THR_W     = 16;
  localparam int VTH_W     = 32;
  localparam int OUT_LAG_W = 10;
  localparam int CONF_W    = 32;
  localparam int PROD_W    = VAL_W + CORR_W;
  localparam int FRAC_W    = 15;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_LAG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LAG   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_THR  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICE_THR = 2'd3;

  localparam logic [CFG_LAG_W-1:0] MIN_LAG_RST   = 11'd63;
  localparam logic [CFG_LAG_W-1:0] MAX_LAG_RST   = 11'd630;
  localparam logic [THR_W-1:0]     PICK_THR_RST  = 16'd29491;
  localparam logic [VTH_W-1:0]     VOICE_THR_RST = 32'd49152;

  // unity in q1.15
  localparam logic [THR_W:0] Q15_ONE = 17'h08000;

  typedef struct packed {
    logic [LAG_W-1:0]        lag;
    logic signed [VAL_W-1:0] val;
    logic [CORR_W-1:0]       corr;
  } peak_entry_t;

  localparam int ENTRY_W = $bits(peak_entry_t);

  typedef struct packed {
    logic        valid;
    logic        found;
    logic        wrapped;
    peak_entry_t entry;
  } result_req_t;

endpackage

// ===== src/mpp_ram.sv =====
`timescale 1ns / 1ps
module mpp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/mpp_result.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mpp_result import mpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  result_req_t           req,
  input  logic [VTH_W-1:0]      voiced_threshold,
  output logic                  free,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // best_lag[9:0], confidence[41:10], voiced[42], store_wrapped[43], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata
);

  logic                 s1_valid;
  logic [OUT_LAG_W-1:0] s1_lag;
  logic [PROD_W-1:0]    s1_prod;
  logic                 s1_wrapped;

  logic [VAL_W-1:0]     val_u;
  logic                 val_pos;
  logic [CONF_W:0]      conf_full;
  logic [CONF_W-1:0]    conf;
  logic                 voiced;
  logic                 move;

  assign val_u   = req.entry.val;
  assign val_pos = !req.entry.val[VAL_W-1] && (req.entry.val != '0);
  assign free    = !s1_valid;
  assign move    = s1_valid && (!m_tvalid || m_tready);

  assign conf_full = s1_prod[PROD_W-1:FRAC_W];
  assign conf      = conf_full[CONF_W] ? {CONF_W{1'b1}} : conf_full[CONF_W-1:0];
  assign voiced    = (conf >= voiced_threshold);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (req.valid) begin
        s1_valid <= 1'b1;
      end else if (move) begin
        s1_valid <= 1'b0;
      end
      if (move) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid) begin
      s1_lag     <= req.found ? OUT_LAG_W'(req.entry.lag) : '0;
      s1_prod    <= (req.found && val_pos) ? val_u * req.entry.corr : '0;
      s1_wrapped <= req.wrapped;
    end
    if (move) begin
      m_tdata <= OUT_DATA_W'({s1_wrapped, voiced, conf, s1_lag});
    end
  end

  `ASSERT_CLK(a_req_into_empty, req.valid |-> !s1_valid, "result request while stage busy")
  `ASSERT_NEXT(a_stage_drains, move, m_tvalid && !s1_valid, "result stage failed to drain")

endmodule

// ===== src/mpm_pitch_peak_picker_unit.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Peak picker for normalised autocorrelation, one lag per word from lag 0,
// a frame closed by tlast. A word is taken in S_IDLE and worked in S_PROC
// in the next cycle. When a positive lobe that raised the frame maximum
// closes, the best pointer walks the peak store one entry a cycle past
// stored peaks below the threshold target, at most up to the write pointer,
// then S_ADV writes the new store slot unless it holds the best entry, which
// stops the search. The word with tlast then reads the best entry from the
// store (S_RES_RD) and waits in S_RES_GO while the previous result still
// sits in the multiply stage behind a stalled output. After that the next
// frame may start while the result (lag, Q16.16 confidence, voiced, store
// wrap) passes a multiply stage and the output register. The store needs no
// clearing after reset; pick_threshold above 1.0 acts as 1.0 and max_lag is
// clamped to the lag limit. Configuration is to be written by the user
// only while no frame is in progress; the block does not enforce it.
module mpm_pitch_peak_picker_unit import mpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // lag_value[15:0], window_correction[47:16]
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // best_lag[9:0], confidence[41:10], voiced[42], store_wrapped[43], zero fill
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_PROC   = 6'b000010,
    S_WALK   = 6'b000100,
    S_ADV    = 6'b001000,
    S_RES_RD = 6'b010000,
    S_RES_GO = 6'b100000
  } state_t;

  typedef enum logic [3:0] {
    PH_SKIP_POS    = 4'b0001,
    PH_SKIP_NONPOS = 4'b0010,
    PH_TO_MIN      = 4'b0100,
    PH_SEARCH      = 4'b1000
  } phase_t;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    return (32'(p) + 1 >= PEAK_DEPTH) ? '0 : p + 1'b1;
  endfunction

  state_t                  state;
  phase_t                  phase;
  logic [LAG_W-1:0]        lag_counter;
  logic signed [VAL_W-1:0] highest_peak;
  logic                    peak_seen;
  logic                    new_maximum;
  logic                    above_zero;
  logic                    search_stopped;
  logic [PTR_W-1:0]        wr_ptr;
  logic [PTR_W-1:0]        best_ptr;

  logic [CFG_LAG_W-1:0]    min_lag;
  logic [CFG_LAG_W-1:0]    max_lag;
  logic [THR_W-1:0]        pick_threshold;
  logic [VTH_W-1:0]        voiced_threshold;

  logic signed [VAL_W-1:0] item_val;
  logic [CORR_W-1:0]       item_corr;
  logic                    item_last;
  logic [LAG_W-1:0]        item_lag;
  peak_entry_t             cur_entry;
  logic signed [THR_W+VAL_W+1:0] target;

  logic [THR_W:0]          thr_c;
  logic [CMP_W-1:0]        lag_ext;
  logic [CMP_W-1:0]        end_lag;
  logic                    in_range;
  logic                    v_pos;
  logic                    v_nonneg;
  phase_t                  ph;
  logic                    done;
  logic                    enter;
  logic                    active;
  logic                    grow;
  logic                    raise;
  logic                    close;
  logic                    below;
  logic                    cur_load;
  peak_entry_t             new_entry;
  peak_entry_t             base_entry;
  peak_entry_t             rd_entry;
  logic [PTR_W-1:0]        base_ptr;
  logic [PTR_W-1:0]        bp_inc;
  logic [PTR_W-1:0]        wp_inc;
  logic signed [THR_W+VAL_W+1:0] val_scaled;

  logic                    ram_we;
  logic [PTR_W-1:0]        ram_waddr;
  logic                    ram_re;
  logic [PTR_W-1:0]        ram_raddr;
  logic [ENTRY_W-1:0]      ram_rdata;

  result_req_t             res_req;
  logic                    res_free;

  assign s_tready = (state == S_IDLE);

  assign thr_c    = ({1'b0, pick_threshold} > Q15_ONE) ? Q15_ONE : {1'b0, pick_threshold};
  assign lag_ext  = CMP_W'(item_lag);
  assign end_lag  = (CMP_W'(max_lag) > CMP_W'(MAX_LAGS)) ? CMP_W'(MAX_LAGS) : CMP_W'(max_lag);
  assign in_range = (lag_ext < end_lag);
  assign v_nonneg = !item_val[VAL_W-1];
  assign v_pos    = v_nonneg && (item_val != '0);

  assign new_entry  = '{lag: item_lag, val: item_val, corr: item_corr};
  assign rd_entry   = peak_entry_t'(ram_rdata);
  assign bp_inc     = ring_next(best_ptr);
  assign wp_inc     = ring_next(wr_ptr);
  assign val_scaled = {{(THR_W + 2 - FRAC_W){rd_entry.val[VAL_W-1]}}, rd_entry.val, FRAC_W'(0)};
  assign below      = (val_scaled < target);

  // lobe-skipping phases, several may pass on one word
  always_comb begin
    ph    = phase;
    done  = 1'b0;
    enter = 1'b0;
    if (ph == PH_SKIP_POS) begin
      if (in_range && v_nonneg) done = 1'b1;
      else ph = PH_SKIP_NONPOS;
    end
    if (!done && ph == PH_SKIP_NONPOS) begin
      if (in_range && !v_pos) done = 1'b1;
      else ph = PH_TO_MIN;
    end
    if (!done && ph == PH_TO_MIN) begin
      if (lag_ext < CMP_W'(min_lag)) begin
        done = 1'b1;
      end else begin
        enter = 1'b1;
        ph    = PH_SEARCH;
      end
    end
  end

  assign active     = !done && (ph == PH_SEARCH) && in_range && !search_stopped;
  assign base_entry = enter ? new_entry : cur_entry;
  assign base_ptr   = enter ? '0 : wr_ptr;
  assign grow       = active && v_pos && (item_val > base_entry.val);
  assign raise      = active && v_pos && (!peak_seen || item_val > highest_peak);
  assign close      = active && !v_pos && above_zero && new_maximum;
  assign cur_load   = ((state == S_PROC) && (enter || grow)) ||
                      ((state == S_ADV) && (wp_inc != best_ptr));

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = base_ptr;
    ram_re    = 1'b0;
    ram_raddr = best_ptr;
    unique case (state)
      S_IDLE: begin
      end
      S_PROC: begin
        ram_we = enter || grow;
        ram_re = close && (best_ptr != wr_ptr);
      end
      S_WALK: begin
        ram_re    = below && (bp_inc != wr_ptr);
        ram_raddr = bp_inc;
      end
      S_ADV: begin
        ram_we    = (wp_inc != best_ptr);
        ram_waddr = wp_inc;
      end
      S_RES_RD: begin
        ram_re = 1'b1;
      end
      S_RES_GO: begin
      end
      default: begin
      end
    endcase
  end

  assign res_req.valid   = (state == S_RES_GO) && res_free;
  assign res_req.found   = peak_seen;
  assign res_req.wrapped = search_stopped;
  assign res_req.entry   = rd_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      phase            <= PH_SKIP_POS;
      lag_counter      <= '0;
      highest_peak     <= '0;
      peak_seen        <= 1'b0;
      new_maximum      <= 1'b0;
      above_zero       <= 1'b1;
      search_stopped   <= 1'b0;
      wr_ptr           <= '0;
      best_ptr         <= '0;
      min_lag          <= MIN_LAG_RST;
      max_lag          <= MAX_LAG_RST;
      pick_threshold   <= PICK_THR_RST;
      voiced_threshold <= VOICE_THR_RST;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_MIN_LAG:   min_lag          <= cfg_data[CFG_LAG_W-1:0];
          CFG_MAX_LAG:   max_lag          <= cfg_data[CFG_LAG_W-1:0];
          CFG_PICK_THR:  pick_threshold   <= cfg_data[THR_W-1:0];
          CFG_VOICE_THR: voiced_threshold <= cfg_data[VTH_W-1:0];
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (32'(lag_counter) < MAX_LAGS) begin
              lag_counter <= lag_counter + 1'b1;
            end
            state <= S_PROC;
          end
        end
        S_PROC: begin
          phase <= ph;
          if (enter) begin
            wr_ptr   <= '0;
            best_ptr <= '0;
          end
          if (raise) begin
            highest_peak <= item_val;
            peak_seen    <= 1'b1;
            new_maximum  <= 1'b1;
          end
          if (active && !close) begin
            above_zero <= v_pos;
          end
          if (close) begin
            state <= (best_ptr != wr_ptr) ? S_WALK : S_ADV;
          end else begin
            state <= item_last ? S_RES_RD : S_IDLE;
          end
        end
        S_WALK: begin
          if (below) begin
            best_ptr <= bp_inc;
            if (bp_inc == wr_ptr) begin
              state <= S_ADV;
            end
          end else begin
            state <= S_ADV;
          end
        end
        S_ADV: begin
          wr_ptr <= wp_inc;
          if (wp_inc == best_ptr) begin
            search_stopped <= 1'b1;
          end else begin
            new_maximum <= 1'b0;
            above_zero  <= 1'b0;
          end
          state <= item_last ? S_RES_RD : S_IDLE;
        end
        S_RES_RD: begin
          state <= S_RES_GO;
        end
        S_RES_GO: begin
          if (res_free) begin
            phase          <= PH_SKIP_POS;
            lag_counter    <= '0;
            highest_peak   <= '0;
            peak_seen      <= 1'b0;
            new_maximum    <= 1'b0;
            above_zero     <= 1'b1;
            search_stopped <= 1'b0;
            wr_ptr         <= '0;
            best_ptr       <= '0;
            state          <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && s_tvalid) begin
      item_val  <= s_tdata[VAL_W-1:0];
      item_corr <= s_tdata[VAL_W+CORR_W-1:VAL_W];
      item_last <= s_tlast;
      item_lag  <= lag_counter;
    end
    if (cur_load) begin
      cur_entry <= new_entry;
    end
    target <= $signed({1'b0, thr_c}) * highest_peak;
  end

  mpp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PEAK_DEPTH)
  ) u_peak_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_entry),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mpp_result u_result (
    .clk              (clk),
    .rst              (rst),
    .req              (res_req),
    .voiced_threshold (voiced_threshold),
    .free             (res_free),
    .m_tvalid         (m_tvalid),
    .m_tready         (m_tready),
    .m_tdata          (m_tdata)
  );

  `ASSERT_CLK(a_walk_behind_head, (state == S_WALK) |-> (best_ptr != wr_ptr), "walk reached write pointer")
  `ASSERT_CLK(a_adv_spares_best, (state == S_ADV) && ram_we |-> (ram_waddr != best_ptr), "new peak overwrote best entry")
  `ASSERT_NEXT(a_frame_cleared, res_req.valid, (lag_counter == '0) && (phase == PH_SKIP_POS), "frame state not cleared after result")

endmodule
